[design/sacl_pkg.sv]
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package sacl_pkg;

   // access kinds
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STORE  = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;

   // outcome codes
   localparam logic [2:0] OUT_HIT          = 3'd0;
   localparam logic [2:0] OUT_MISS         = 3'd1;
   localparam logic [2:0] OUT_MISS_HIT     = 3'd2;
   localparam logic [2:0] OUT_EVICT        = 3'd3;
   localparam logic [2:0] OUT_EVICT_HIT    = 3'd4;

   // register indexes
   localparam logic [1:0] REG_SET_BITS = 2'd0;
   localparam logic [1:0] REG_OFF_BITS = 2'd1;
   localparam logic [1:0] REG_WAYS     = 2'd2;

   localparam int CNT_W = 32;

   // controller -> datapath commands
   typedef struct packed {
      logic clear;     // clear one row of valid bits after reset
      logic capture;   // latch the request and read the set
      logic update;    // write back the set, bump counters, present result
   } ctl_cmd_type;

endpackage

[design/sacl_datapath.sv]
// ----------------------------------------------------------------------------
// sacl_datapath
// Set storage, way compare, LRU age update and saturating counters.
// ----------------------------------------------------------------------------
module sacl_datapath #(
   parameter int MAX_SET_INDEX_BITS = 6,
   parameter int MAX_WAYS           = 8,
   parameter int ADDRESS_BITS       = 48
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sacl_pkg::ctl_cmd_type     cmd,
   output logic                      clr_done,
   input  logic [1:0]                req_opcode,
   input  logic [ADDRESS_BITS-1:0]   req_address,
   input  logic [2:0]                cfg_set_bits,
   input  logic [4:0]                cfg_off_bits,
   input  logic [3:0]                cfg_ways,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_outcome,
   output logic [31:0]               rsp_hit_total,
   output logic [31:0]               rsp_miss_total,
   output logic [31:0]               rsp_eviction_total
);
   import sacl_pkg::*;

   localparam int SETS  = 1 << MAX_SET_INDEX_BITS;
   localparam int SW    = (MAX_SET_INDEX_BITS > 0) ? MAX_SET_INDEX_BITS : 1;
   localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int AGW   = 3;
   localparam int WCW   = $clog2(MAX_WAYS + 1);

   typedef logic [ADDRESS_BITS-1:0] tag_type;
   typedef logic [AGW-1:0]          age_type;

   // set memories: one row per set, read data registered
   logic [MAX_WAYS*ADDRESS_BITS-1:0] tag_mem [SETS];
   logic [MAX_WAYS*AGW-1:0]          age_mem [SETS];
   logic [MAX_WAYS*ADDRESS_BITS-1:0] tag_row_ff;
   logic [MAX_WAYS*AGW-1:0]          age_row_ff;
   logic [MAX_WAYS-1:0]              valid_mem [SETS];
   logic [MAX_WAYS-1:0]              vrow_ff;
   logic [SW-1:0]                    clr_ff;

   logic [SW-1:0]          set_ff, set_in;
   tag_type                tag_ff, tag_in;
   logic                   mod_ff;
   logic [WCW-1:0]         ways_ff, ways_in;

   logic [31:0] hit_ff, miss_ff, evict_ff;
   logic [2:0]  outc_ff;
   logic        rv_ff;

   // effective set bits, ways, set and tag
   logic [3:0] s_eff;
   logic [5:0] sb;
   always_comb begin
      s_eff   = (32'(cfg_set_bits) > MAX_SET_INDEX_BITS) ? 4'(MAX_SET_INDEX_BITS)
                                                         : {1'b0, cfg_set_bits};
      sb      = 6'(s_eff) + 6'(cfg_off_bits);
      if (cfg_ways == 4'd0)
         ways_in = WCW'(1);
      else if (32'(cfg_ways) > MAX_WAYS)
         ways_in = WCW'(MAX_WAYS);
      else
         ways_in = WCW'(cfg_ways);
      set_in = SW'((req_address >> cfg_off_bits) & ((ADDRESS_BITS'(1) << s_eff) - 1'b1));
      tag_in = req_address >> sb;
   end

   // capture stage: latch request and read the row
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         set_ff     <= set_in;
         tag_ff     <= tag_in;
         mod_ff     <= (req_opcode == OP_MODIFY);
         ways_ff    <= ways_in;
         tag_row_ff <= tag_mem[set_in];
         age_row_ff <= age_mem[set_in];
      end
   end

   // way compare, victim pick, LRU update
   logic [MAX_WAYS-1:0] inuse, hitv, emptyv;
   logic                hit, has_empty;
   logic [WW-1:0]       hit_w, empty_w, vic_w, tgt_w;
   age_type             ref_age, top_age, vic_age;
   logic [MAX_WAYS*AGW-1:0]          age_new;
   logic [MAX_WAYS*ADDRESS_BITS-1:0] tag_new;
   logic [MAX_WAYS-1:0]              vrow_new;
   logic                             fill;
   logic [2:0]                       outc_in;

   always_comb begin
      hit = 1'b0; has_empty = 1'b0;
      hit_w = '0; empty_w = '0; vic_w = '0;
      vic_age = age_row_ff[AGW-1:0];
      for (int i = 0; i < MAX_WAYS; i++) begin
         inuse[i]  = (WCW'(i) < ways_ff);
         hitv[i]   = inuse[i] && vrow_ff[i] &&
                     (tag_row_ff[i*ADDRESS_BITS +: ADDRESS_BITS] == tag_ff);
         emptyv[i] = inuse[i] && !vrow_ff[i];
      end
      // lowest-index priority scans, run from the top down
      for (int i = MAX_WAYS-1; i >= 0; i--) begin
         if (hitv[i])   begin hit = 1'b1; hit_w = WW'(i); end
         if (emptyv[i]) begin has_empty = 1'b1; empty_w = WW'(i); end
      end
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (inuse[i] && age_row_ff[i*AGW +: AGW] < vic_age) begin
            vic_age = age_row_ff[i*AGW +: AGW];
            vic_w   = WW'(i);
         end
      end
      fill  = !hit && has_empty;
      tgt_w = hit ? hit_w : (has_empty ? empty_w : vic_w);
      ref_age = age_row_ff[tgt_w*AGW +: AGW];
      top_age = AGW'(ways_ff - 1'b1);
      age_new = age_row_ff;
      tag_new = tag_row_ff;
      vrow_new = vrow_ff;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WW'(i) == tgt_w)
            age_new[i*AGW +: AGW] = top_age;
         else if (inuse[i] && vrow_ff[i]) begin
            if (fill ? (age_row_ff[i*AGW +: AGW] != '0)
                     : (age_row_ff[i*AGW +: AGW] > ref_age))
               age_new[i*AGW +: AGW] = age_row_ff[i*AGW +: AGW] - 1'b1;
         end
      end
      if (!hit) begin
         tag_new[tgt_w*ADDRESS_BITS +: ADDRESS_BITS] = tag_ff;
         vrow_new[tgt_w] = 1'b1;
      end
      if (hit)            outc_in = OUT_HIT;
      else if (has_empty) outc_in = mod_ff ? OUT_MISS_HIT  : OUT_MISS;
      else                outc_in = mod_ff ? OUT_EVICT_HIT : OUT_EVICT;
   end

   // write back the row
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         tag_mem[set_ff] <= tag_new;
         age_mem[set_ff] <= age_new;
      end
   end

   // valid bits: one row cleared per cycle after reset, then one row per update
   always_ff @(posedge clock) begin
      if (cmd.clear)
         valid_mem[clr_ff] <= '0;
      else if (cmd.update)
         valid_mem[set_ff] <= vrow_new;
      if (cmd.capture)
         vrow_ff <= valid_mem[set_in];
   end

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset)          clr_ff <= '0;
      else if (cmd.clear) clr_ff <= clr_ff + 1'b1;
   end

   assign clr_done = (clr_ff == SW'(SETS - 1));

   // counters
   function automatic logic [31:0] sat_add(logic [31:0] v, logic [1:0] n);
      logic [32:0] t;
      t = 33'(v) + 33'(n);
      return t[32] ? 32'hFFFF_FFFF : t[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= '0; miss_ff <= '0; evict_ff <= '0;
         rv_ff  <= 1'b0;
      end else begin
         rv_ff <= cmd.update;
         if (cmd.update) begin
            hit_ff   <= sat_add(hit_ff, hit ? {mod_ff, !mod_ff} : {1'b0, mod_ff});
            miss_ff  <= sat_add(miss_ff, {1'b0, !hit});
            evict_ff <= sat_add(evict_ff, {1'b0, !hit && !has_empty});
            outc_ff  <= outc_in;
         end
      end
   end

   assign rsp_valid          = rv_ff;
   assign rsp_outcome        = outc_ff;
   assign rsp_hit_total      = hit_ff;
   assign rsp_miss_total     = miss_ff;
   assign rsp_eviction_total = evict_ff;
endmodule

[design/sacl_ctrl.sv]
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer: valid clear after reset, then capture/read, update/write back.
// ----------------------------------------------------------------------------
module sacl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_start,
   input  logic                  clr_done,
   output logic                  busy,
   output sacl_pkg::ctl_cmd_type cmd
);
   import sacl_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_UPD  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;
   localparam logic [1:0] ST_CLR  = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.clear   = 1'b0;
      cmd.capture = 1'b0;
      cmd.update  = 1'b0;
      unique case (state_ff)
         ST_CLR: begin
            cmd.clear = 1'b1;
            if (clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_start) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLR;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

[design/set_assoc_cache_lru_sim.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Set-associative cache hit/miss model with true LRU ages.
//
//   channel  signals                         direction
//   req      start, busy, req_opcode/address in
//   rsp      rsp_valid + outcome, totals     out, one-cycle strobe
//   csr      csr_valid/ready, index, data    in
//
// A transaction passes the sequencer states in order: the set row is read when
// the request is accepted, compared and written back in the update state, and
// the result strobe follows in the output state before the sequencer is idle
// again. A new request is taken once busy drops. Reset clears the counters at
// once; the valid bits are then cleared one set per cycle, so busy stays high
// after reset until every set is cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim #(
   parameter int MAX_SET_INDEX_BITS = 6,
   parameter int MAX_WAYS           = 8,
   parameter int ADDRESS_BITS       = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_opcode,
   input  logic [ADDRESS_BITS-1:0] req_address,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_outcome,
   output logic [31:0]             rsp_hit_total,
   output logic [31:0]             rsp_miss_total,
   output logic [31:0]             rsp_eviction_total,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [31:0]             csr_data
);
   import sacl_pkg::*;

   logic [2:0] set_bits_ff;
   logic [4:0] off_bits_ff;
   logic [3:0] ways_ff;
   ctl_cmd_type cmd;
   logic clr_done;

   // config registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff <= 3'd0;
         off_bits_ff <= 5'd4;
         ways_ff     <= 4'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SET_BITS: set_bits_ff <= csr_data[2:0];
            REG_OFF_BITS: off_bits_ff <= csr_data[4:0];
            REG_WAYS:     ways_ff     <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   sacl_ctrl u_ctrl (
      .clock, .reset, .req_start(start), .clr_done, .busy, .cmd
   );

   sacl_datapath #(
      .MAX_SET_INDEX_BITS(MAX_SET_INDEX_BITS),
      .MAX_WAYS(MAX_WAYS),
      .ADDRESS_BITS(ADDRESS_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .clr_done,
      .req_opcode, .req_address,
      .cfg_set_bits(set_bits_ff), .cfg_off_bits(off_bits_ff), .cfg_ways(ways_ff),
      .rsp_valid, .rsp_outcome, .rsp_hit_total, .rsp_miss_total, .rsp_eviction_total
   );
endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative LRU cache model. A short table
// of directed accesses and register writes runs first, then phases of random
// accesses under fixed and random cache geometries. Every result is checked
// against an in-bench LRU cache model; directed rows can set the outcome.
// ----------------------------------------------------------------------------
module tb;
   import sacl_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;   // decoded as a load
   localparam logic [1:0] REG_NONE  = 2'd3;   // unmapped register index
   localparam int ADDR_W      = 48;
   localparam int SET_BITS_MX = 6;
   localparam int WAYS_MX     = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 80;

   typedef struct packed {
      logic [2:0]  outcome;
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] evictions;
   } access_result_type;

   typedef struct packed {
      logic              is_cfg;
      logic [1:0]        code;      // opcode, or register index
      logic [ADDR_W-1:0] value;     // address, or register data
      logic              has_exp;
      logic [2:0]        outcome;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_opcode = '0;
   logic [ADDR_W-1:0] req_address = '0;
   logic rsp_valid;
   logic [2:0] rsp_outcome;
   logic [31:0] rsp_hit_total, rsp_miss_total, rsp_eviction_total;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   set_assoc_cache_lru_sim uut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // ---- cache model state ----
   logic [2:0] cfg_set_bits = 3'd0;
   logic [4:0] cfg_off_bits = 5'd4;
   logic [3:0] cfg_ways     = 4'd1;
   logic              line_ok  [0:(1<<SET_BITS_MX)*WAYS_MX-1];
   logic [ADDR_W-1:0] line_tag [0:(1<<SET_BITS_MX)*WAYS_MX-1];
   logic [2:0]        line_age [0:(1<<SET_BITS_MX)*WAYS_MX-1];
   logic [31:0] hit_cnt = '0, miss_cnt = '0, evict_cnt = '0;

   access_result_type pending_results[$];
   int errors = 0;
   int checked = 0;
   int cycles = 0;
   int burst_left = 0;

   initial begin
      for (int i = 0; i < (1<<SET_BITS_MX)*WAYS_MX; i++) line_ok[i] = 1'b0;
   end

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // make way tgt the newest; a fill ages every other valid way
   function automatic void lru_touch(input int base, input int ways, input int tgt,
                                     input bit fill);
      logic [2:0] ref_age;
      ref_age = line_age[base + tgt];
      for (int i = 0; i < ways; i++) begin
         if (i != tgt && line_ok[base + i]) begin
            if (fill) begin
               if (line_age[base + i] > 0) line_age[base + i]--;
            end else if (line_age[base + i] > ref_age) begin
               line_age[base + i]--;
            end
         end
      end
      line_age[base + tgt] = 3'(ways - 1);
   endfunction

   function automatic access_result_type cache_access(input logic [1:0] op,
                                                      input logic [ADDR_W-1:0] addr);
      access_result_type r;
      int s, b, ways, base, hit_way, free_way, victim;
      logic [ADDR_W-1:0] tag;
      s = (cfg_set_bits > SET_BITS_MX) ? SET_BITS_MX : cfg_set_bits;
      b = cfg_off_bits;
      ways = (cfg_ways == 0) ? 1 : (cfg_ways > WAYS_MX) ? WAYS_MX : cfg_ways;
      base = int'((addr >> b) & ((48'd1 << s) - 1)) * WAYS_MX;
      tag = addr >> (s + b);
      hit_way = -1;
      free_way = -1;
      for (int i = ways - 1; i >= 0; i--) begin
         if (line_ok[base + i] && line_tag[base + i] == tag) hit_way = i;
         if (!line_ok[base + i]) free_way = i;
      end
      if (hit_way >= 0) begin
         hit_cnt = sat_inc(hit_cnt);
         if (op == OP_MODIFY) hit_cnt = sat_inc(hit_cnt);
         lru_touch(base, ways, hit_way, 1'b0);
         r.outcome = OUT_HIT;
      end else begin
         miss_cnt = sat_inc(miss_cnt);
         if (free_way >= 0) begin
            line_ok[base + free_way] = 1'b1;
            line_tag[base + free_way] = tag;
            lru_touch(base, ways, free_way, 1'b1);
            r.outcome = OUT_MISS;
         end else begin
            evict_cnt = sat_inc(evict_cnt);
            victim = 0;
            for (int i = 1; i < ways; i++)
               if (line_age[base + i] < line_age[base + victim]) victim = i;
            line_tag[base + victim] = tag;
            lru_touch(base, ways, victim, 1'b0);
            r.outcome = OUT_EVICT;
         end
         if (op == OP_MODIFY) begin
            hit_cnt = sat_inc(hit_cnt);
            r.outcome = (r.outcome == OUT_MISS) ? OUT_MISS_HIT : OUT_EVICT_HIT;
         end
      end
      r.hits = hit_cnt;
      r.misses = miss_cnt;
      r.evictions = evict_cnt;
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got,
                         input logic [31:0] want);
      $display("tb: %0t mismatch %s got %0h expected %0h", $time, what, got, want);
      errors++;
   endtask

   // ---- result checker ----
   always @(posedge clock) begin
      access_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("tb: %0t unexpected result transaction", $time);
            errors++;
         end else begin
            e = pending_results.pop_front();
            checked++;
            if (rsp_outcome !== e.outcome) report("outcome", 32'(rsp_outcome), 32'(e.outcome));
            if (rsp_hit_total !== e.hits) report("hit_total", rsp_hit_total, e.hits);
            if (rsp_miss_total !== e.misses) report("miss_total", rsp_miss_total, e.misses);
            if (rsp_eviction_total !== e.evictions)
               report("eviction_total", rsp_eviction_total, e.evictions);
         end
      end
   end

   // ---- watchdog ----
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: timeout with %0d results outstanding", pending_results.size());
         $display("tb: errors");
         $finish;
      end
   end

   // one register write; valid is left high for a following write
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_SET_BITS: cfg_set_bits = data[2:0];
         REG_OFF_BITS: cfg_off_bits = data[4:0];
         REG_WAYS:     cfg_ways = data[3:0];
         default: ;
      endcase
   endtask

   // wait for the block to drain before touching registers
   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // one access transaction with bursty pacing
   task automatic send_access(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                              input bit has_exp, input logic [2:0] exp_outcome);
      access_result_type r;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (start) start <= 1'b0;
         if (start || $urandom_range(0, 1)) repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      burst_left--;
      start <= 1'b1;
      req_opcode <= op;
      req_address <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = cache_access(op, addr);
      if (has_exp) r.outcome = exp_outcome;
      pending_results.push_back(r);
   endtask

   task automatic quiesce();
      if (start) start <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      drain();
   endtask

   stim_row_type dir_rows [0:20] = '{
      '{1'b0, OP_LOAD,   48'h0,              1'b1, OUT_MISS},
      '{1'b0, OP_LOAD,   48'hF,              1'b1, OUT_HIT},
      '{1'b0, OP_MODIFY, 48'hFFFF_FFFF_FFFF, 1'b1, OUT_EVICT_HIT},
      '{1'b0, OP_STORE,  48'h10,             1'b1, OUT_EVICT},
      '{1'b0, OP_UNUSED, 48'h10,             1'b1, OUT_HIT},
      // oversized set count, masked offset width, zero ways
      '{1'b1, REG_SET_BITS, 48'h7,           1'b0, OUT_HIT},
      '{1'b1, REG_OFF_BITS, 48'hFFFF_FFE0,   1'b0, OUT_HIT},
      '{1'b1, REG_WAYS,     48'hFFFF_FFF0,   1'b0, OUT_HIT},
      '{1'b1, REG_NONE,     48'hFFFF_FFFF,   1'b0, OUT_HIT},
      '{1'b0, OP_LOAD,   48'h0,              1'b0, OUT_HIT},
      // oversized way count, then fill and overflow set 0
      '{1'b1, REG_WAYS,     48'hF,           1'b0, OUT_HIT},
      '{1'b0, OP_LOAD,   48'h40,             1'b0, OUT_HIT},
      '{1'b0, OP_STORE,  48'h80,             1'b0, OUT_HIT},
      '{1'b0, OP_LOAD,   48'hC0,             1'b0, OUT_HIT},
      '{1'b0, OP_LOAD,   48'h100,            1'b0, OUT_HIT},
      '{1'b0, OP_LOAD,   48'h140,            1'b0, OUT_HIT},
      '{1'b0, OP_LOAD,   48'h1C0,            1'b0, OUT_HIT},
      '{1'b0, OP_LOAD,   48'h200,            1'b0, OUT_HIT},
      '{1'b0, OP_LOAD,   48'h240,            1'b0, OUT_HIT},
      '{1'b0, OP_MODIFY, 48'h40,             1'b0, OUT_HIT},
      '{1'b0, OP_MODIFY, 48'hFFFF_FFFF_FFC0, 1'b0, OUT_HIT}
   };

   // ---- stimulus ----
   initial begin
      logic [2:0] s_cfg;
      logic [4:0] b_cfg;
      logic [3:0] w_cfg;
      logic [ADDR_W-1:0] addr;
      int s_eff, w_eff;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            if (start) quiesce();
            csr_write(dir_rows[i].code, dir_rows[i].value[31:0]);
            if (i + 1 > $high(dir_rows) || !dir_rows[i + 1].is_cfg) csr_valid <= 1'b0;
         end else begin
            send_access(dir_rows[i].code, dir_rows[i].value,
                        dir_rows[i].has_exp, dir_rows[i].outcome);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         quiesce();
         case (p)
            0: begin s_cfg = 3'd0; b_cfg = 5'd0;  w_cfg = 4'd1; end
            1: begin s_cfg = 3'd6; b_cfg = 5'd31; w_cfg = 4'd8; end
            2: begin s_cfg = 3'd1; b_cfg = 5'd16; w_cfg = 4'd4; end
            default: begin
               s_cfg = 3'($urandom_range(0, 7));
               b_cfg = 5'($urandom_range(0, 31));
               w_cfg = 4'($urandom_range(0, 15));
            end
         endcase
         csr_write(REG_SET_BITS, {$urandom} & 32'hFFFF_FFF8 | 32'(s_cfg));
         csr_write(REG_OFF_BITS, {$urandom} & 32'hFFFF_FFE0 | 32'(b_cfg));
         csr_write(REG_WAYS,     {$urandom} & 32'hFFFF_FFF0 | 32'(w_cfg));
         csr_valid <= 1'b0;
         s_eff = (s_cfg > SET_BITS_MX) ? SET_BITS_MX : s_cfg;
         w_eff = (w_cfg == 0) ? 1 : (w_cfg > WAYS_MX) ? WAYS_MX : w_cfg;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 7) == 0) begin
               addr = 48'({$urandom, $urandom});
            end else begin
               // a handful of tags over a couple of sets keeps the sets busy
               addr = (48'($urandom_range(0, w_eff + 2)) << (s_eff + b_cfg))
                    | ((48'($urandom) & ((48'd1 << s_eff) - 1) & 48'h3) << b_cfg)
                    | (48'($urandom) & ((48'd1 << b_cfg) - 1));
            end
            send_access(2'($urandom_range(0, 3)), addr, 1'b0, OUT_HIT);
         end
      end

      if (start) start <= 1'b0;
      @(posedge clock);
      drain();
      $display("tb: %0d results checked over %0d cache geometries", checked, PHASES + 3);
      $display("tb: directed table plus random loads, stores and modifies");
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

[set_assoc_cache_lru_sim.f]
design/sacl_pkg.sv
design/sacl_datapath.sv
design/sacl_ctrl.sv
design/set_assoc_cache_lru_sim.sv
bench/tb.sv
